// ===== src/pcrob_pkg.sv =====
package pcrob_pkg;

  localparam int unsigned TAG_W            = 8;
  localparam int unsigned POC_W            = 32;
  localparam int unsigned DEPTH_W          = 5;
  // Slot select width covers the largest supported buffer (32 slots)
  localparam int unsigned SLOT_W           = 5;
  localparam int unsigned BUFFER_DEPTH_DEF = 16;

  localparam logic KIND_PIC   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [TAG_W-1:0]        pic_tag;
    logic signed [POC_W-1:0] pic_poc;
  } req_t;

  typedef struct packed {
    logic                    out_valid;
    logic [TAG_W-1:0]        out_tag;
    logic signed [POC_W-1:0] out_poc;
    logic [DEPTH_W-1:0]      held_count;
  } result_t;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [POC_W-1:0] poc;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SHIFT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] sel;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  function automatic logic poc_less(input logic signed [POC_W-1:0] a,
                                    input logic signed [POC_W-1:0] b);
    return a < b;
  endfunction

endpackage

// ===== src/pcrob_cell.sv =====
module pcrob_cell #(
  parameter int unsigned SLOT = 0
) (
  input  logic                 clk,
  input  pcrob_pkg::cell_cmd_t cmd,
  input  pcrob_pkg::entry_t    nbr,
  input  pcrob_pkg::entry_t    new_entry,
  output pcrob_pkg::entry_t    entry
);

  localparam logic [pcrob_pkg::SLOT_W-1:0] SLOT_ID = pcrob_pkg::SLOT_W'(SLOT);

  pcrob_pkg::entry_t entry_r;
  pcrob_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      pcrob_pkg::CELL_ROTATE: entry_nxt = nbr;
      pcrob_pkg::CELL_SHIFT: begin
        // close the gap: slots at and above the removed one move down
        if (SLOT_ID >= cmd.sel) entry_nxt = nbr;
      end
      pcrob_pkg::CELL_LOAD: begin
        if (SLOT_ID == cmd.sel) entry_nxt = new_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== src/pcrob_ctrl.sv =====
module pcrob_ctrl #(
  parameter int unsigned BUFFER_DEPTH = pcrob_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  pcrob_pkg::req_t                 in_data,
  input  logic                            cfg_we,
  input  logic [pcrob_pkg::DEPTH_W-1:0]   cfg_wdata,
  input  pcrob_pkg::entry_t               head,
  output pcrob_pkg::cell_cmd_t            cmd,
  output pcrob_pkg::entry_t               new_entry,
  output logic                            out_strobe,
  output pcrob_pkg::result_t              out_data
);

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  pcrob_pkg::state_t   state_r, state_nxt;
  logic [pcrob_pkg::DEPTH_W-1:0] depth_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    step_r;
  logic [IDX_W-1:0]    best_idx_r;
  pcrob_pkg::entry_t   best_r;
  pcrob_pkg::req_t     req_r;
  logic                out_strobe_r, out_strobe_nxt;
  pcrob_pkg::result_t  out_data_r, out_data_nxt;

  logic [CNT_W-1:0]    depth_eff;
  logic                accept;
  logic                need_scan;
  logic                scan_last;
  logic                scan_take;
  logic [31:0]         cnt_ext;

  assign busy   = (state_r != pcrob_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (32'(depth_r) > BUFFER_DEPTH) depth_eff = CNT_W'(BUFFER_DEPTH);
    else depth_eff = CNT_W'(depth_r);
  end

  // Requests that must find the held minimum first
  always_comb begin
    need_scan = 1'b0;
    if (depth_eff != '0) begin
      if (in_data.kind == pcrob_pkg::KIND_PIC) need_scan = (count_r >= depth_eff);
      else need_scan = (count_r != '0);
    end
  end

  assign scan_last = (step_r == IDX_W'(BUFFER_DEPTH - 1));
  // cell 0 holds slot step_r during the scan; strict compare keeps the lowest slot on ties
  assign scan_take = (32'(step_r) < 32'(count_r)) &&
                     ((step_r == '0) || pcrob_pkg::poc_less(head.poc, best_r.poc));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcrob_pkg::ST_IDLE:  if (accept && need_scan) state_nxt = pcrob_pkg::ST_SCAN;
      pcrob_pkg::ST_SCAN:  if (scan_last) state_nxt = pcrob_pkg::ST_APPLY;
      pcrob_pkg::ST_APPLY: state_nxt = pcrob_pkg::ST_IDLE;
      default:             state_nxt = pcrob_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op         = pcrob_pkg::CELL_HOLD;
    cmd.sel        = '0;
    new_entry.tag  = req_r.pic_tag;
    new_entry.poc  = req_r.pic_poc;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;
    count_nxt      = count_r;
    case (state_r)
      pcrob_pkg::ST_IDLE: begin
        new_entry.tag = in_data.pic_tag;
        new_entry.poc = in_data.pic_poc;
        if (accept && !need_scan) begin
          out_strobe_nxt = 1'b1;
          if (depth_eff == '0) begin
            if (in_data.kind == pcrob_pkg::KIND_PIC) begin
              out_data_nxt.out_valid = 1'b1;
              out_data_nxt.out_tag   = in_data.pic_tag;
              out_data_nxt.out_poc   = in_data.pic_poc;
            end
          end else if (in_data.kind == pcrob_pkg::KIND_PIC) begin
            // append at the first free slot
            cmd.op    = pcrob_pkg::CELL_LOAD;
            cmd.sel   = pcrob_pkg::SLOT_W'(count_r);
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      pcrob_pkg::ST_SCAN: begin
        cmd.op = pcrob_pkg::CELL_ROTATE;
      end
      pcrob_pkg::ST_APPLY: begin
        out_strobe_nxt         = 1'b1;
        out_data_nxt.out_valid = 1'b1;
        out_data_nxt.out_tag   = best_r.tag;
        out_data_nxt.out_poc   = best_r.poc;
        cmd.sel                = pcrob_pkg::SLOT_W'(best_idx_r);
        if (req_r.kind == pcrob_pkg::KIND_PIC) begin
          if (pcrob_pkg::poc_less(req_r.pic_poc, best_r.poc)) begin
            out_data_nxt.out_tag = req_r.pic_tag;
            out_data_nxt.out_poc = req_r.pic_poc;
          end else begin
            cmd.op = pcrob_pkg::CELL_LOAD;
          end
        end else begin
          cmd.op    = pcrob_pkg::CELL_SHIFT;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
    cnt_ext                 = 32'(count_nxt);
    out_data_nxt.held_count = cnt_ext[pcrob_pkg::DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pcrob_pkg::ST_IDLE;
      depth_r      <= '0;
      count_r      <= '0;
      step_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) depth_r <= cfg_wdata;
      if (state_r == pcrob_pkg::ST_SCAN) step_r <= step_r + IDX_W'(1);
      else step_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) req_r <= in_data;
    if ((state_r == pcrob_pkg::ST_SCAN) && scan_take) begin
      best_r     <= head;
      best_idx_r <= step_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== src/picture_reorder_output_buffer_core.sv =====
// Display reordering buffer: holds up to min(reorder_depth, BUFFER_DEPTH) decoded
// pictures and bumps them out in picture order count order. Every accepted
// request gives exactly one result, shown for a single cycle with out_strobe;
// the receiver must take it then. A request that appends, passes through or
// finds nothing to drain returns its result in the cycle after acceptance. A
// request that bumps or drains rotates the whole cell ring once to find the
// minimum and then updates it before its result appears; busy stays high
// through the scan and the update and drops as the result is shown.
module picture_reorder_output_buffer_core #(
  parameter int unsigned BUFFER_DEPTH = pcrob_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pcrob_pkg::req_t               in_data,
  output logic                          out_strobe,
  output pcrob_pkg::result_t            out_data,
  input  logic                          cfg_we,
  input  logic [pcrob_pkg::DEPTH_W-1:0] cfg_wdata
);

  pcrob_pkg::cell_cmd_t cmd;
  pcrob_pkg::entry_t    new_entry;
  pcrob_pkg::entry_t    ent [BUFFER_DEPTH];

  pcrob_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (ent[0]),
    .cmd       (cmd),
    .new_entry (new_entry),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  // Each cell takes from its upper neighbor; the top cell closes the ring from cell 0
  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    pcrob_cell #(
      .SLOT(i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .nbr      (ent[(i + 1) % BUFFER_DEPTH]),
      .new_entry(new_entry),
      .entry    (ent[i])
    );
  end

endmodule
